FILE: sv/gpm_pkg.sv
// Shared types and constants for the greedy partner matching block.
package gpm_pkg;

  localparam int MAX_STATES = 64;
  localparam int ST_IDX_W   = $clog2(MAX_STATES);
  localparam int N_W        = ST_IDX_W + 1;
  localparam int W_W        = 25;
  localparam int ADDR_W     = $clog2(MAX_STATES * MAX_STATES);
  localparam int TOTAL_W    = ADDR_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 25;

  localparam logic [N_W-1:0] NUM_STATES_MIN = N_W'(2);
  localparam logic [N_W-1:0] NUM_STATES_MAX = N_W'(MAX_STATES);
  localparam logic [N_W-1:0] NUM_STATES_RST = N_W'(MAX_STATES);
  localparam logic [W_W-1:0] THRESHOLD_RST  = W_W'(17);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_STATES,
    REG_MATCH_THRESHOLD
  } gpm_reg_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_PAIR_A,
    ST_PAIR_B,
    ST_EMIT_RD,
    ST_EMIT_WR
  } gpm_state_t;

  typedef struct packed {
    logic in_rdy;
    logic scan_issue;
    logic pair_a;
    logic pair_b;
    logic emit_load;
  } gpm_cmd_t;

  typedef struct packed {
    logic run_go;
    logic scan_last;
    logic found;
    logic out_free;
    logic emit_last;
  } gpm_status_t;

endpackage

FILE: sv/gpm_ifs.sv
// Handshake channel interfaces for weight items and result items.
interface gpm_in_if;
  logic                    valid;
  logic                    ready;
  logic [gpm_pkg::W_W-1:0] weight;

  modport source (output valid, output weight, input ready);
  modport sink (input valid, input weight, output ready);
endinterface

interface gpm_out_if;
  logic                         valid;
  logic                         ready;
  logic [gpm_pkg::ST_IDX_W-1:0] state_index;
  logic [gpm_pkg::ST_IDX_W-1:0] partner_index;
  logic                         paired;
  logic                         last_result;

  modport source (output valid, output state_index, output partner_index,
                  output paired, output last_result, input ready);
  modport sink (input valid, input state_index, input partner_index,
                input paired, input last_result, output ready);
endinterface

FILE: sv/greedy_partner_matching.sv
// Top level: greedy partner matching over a stored weight matrix.
// Sequence: weight items are accepted while loading; after the last weight, scan passes
//   read the matrix, each found pair is recorded in PAIR_A and PAIR_B, and then one result
//   leaves per state. No new weights are accepted until the last result is in the output
//   register. During scans, one weight memory entry is read per cycle.
// Reset: synchronous active-low; num_states 64, threshold 17, load count zero; no clear pass.
module greedy_partner_matching (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gpm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  gpm_in_if.sink                         in_ch,
  gpm_out_if.source                      out_ch
);

  gpm_pkg::gpm_cmd_t    cmd;
  gpm_pkg::gpm_status_t sts;

  gpm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  gpm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

endmodule

FILE: sv/gpm_ctrl.sv
// Sequencer for loading, scan passes, pairing and result output.
module gpm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gpm_pkg::gpm_status_t sts,
  output gpm_pkg::gpm_cmd_t    cmd
);

  gpm_pkg::gpm_state_t state_r;
  gpm_pkg::gpm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gpm_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gpm_pkg::ST_LOAD: begin
        if (sts.run_go) state_nxt = gpm_pkg::ST_SCAN;
      end
      gpm_pkg::ST_SCAN: begin
        if (sts.scan_last) state_nxt = gpm_pkg::ST_SCAN_END;
      end
      gpm_pkg::ST_SCAN_END: state_nxt = gpm_pkg::ST_DECIDE;
      gpm_pkg::ST_DECIDE: begin
        state_nxt = sts.found ? gpm_pkg::ST_PAIR_A : gpm_pkg::ST_EMIT_RD;
      end
      gpm_pkg::ST_PAIR_A: state_nxt = gpm_pkg::ST_PAIR_B;
      gpm_pkg::ST_PAIR_B: state_nxt = gpm_pkg::ST_SCAN;
      gpm_pkg::ST_EMIT_RD: state_nxt = gpm_pkg::ST_EMIT_WR;
      gpm_pkg::ST_EMIT_WR: begin
        if (sts.out_free) begin
          state_nxt = sts.emit_last ? gpm_pkg::ST_LOAD : gpm_pkg::ST_EMIT_RD;
        end
      end
      default: state_nxt = gpm_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      gpm_pkg::ST_LOAD:    cmd.in_rdy     = 1'b1;
      gpm_pkg::ST_SCAN:    cmd.scan_issue = 1'b1;
      gpm_pkg::ST_PAIR_A:  cmd.pair_a     = 1'b1;
      gpm_pkg::ST_PAIR_B:  cmd.pair_b     = 1'b1;
      gpm_pkg::ST_EMIT_WR: cmd.emit_load  = 1'b1;
      default:             cmd = '0;
    endcase
  end

endmodule

FILE: sv/gpm_dp.sv
// Datapath: weight memory, scan comparator, used flags, partner memory, output register.
module gpm_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [gpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gpm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  gpm_pkg::gpm_cmd_t                cmd,
  output gpm_pkg::gpm_status_t             sts,
  gpm_in_if.sink                           in_ch,
  gpm_out_if.source                        out_ch
);

  localparam int SW = gpm_pkg::ST_IDX_W;
  localparam int NW = gpm_pkg::N_W;
  localparam int WW = gpm_pkg::W_W;
  localparam int AW = gpm_pkg::ADDR_W;
  localparam int TW = gpm_pkg::TOTAL_W;

  // configuration
  logic [NW-1:0] n_r;
  logic [WW-1:0] thr_r;
  logic [NW-1:0] cfg_n_sat;

  always_comb begin
    cfg_n_sat = cfg_wdata[NW-1:0];
    if (cfg_n_sat < gpm_pkg::NUM_STATES_MIN) cfg_n_sat = gpm_pkg::NUM_STATES_MIN;
    if (cfg_n_sat > gpm_pkg::NUM_STATES_MAX) cfg_n_sat = gpm_pkg::NUM_STATES_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= gpm_pkg::NUM_STATES_RST;
      thr_r <= gpm_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      case (gpm_pkg::gpm_reg_t'(cfg_index))
        gpm_pkg::REG_NUM_STATES:      n_r   <= cfg_n_sat;
        gpm_pkg::REG_MATCH_THRESHOLD: thr_r <= cfg_wdata[WW-1:0];
        default: ;
      endcase
    end
  end

  logic [TW-1:0] total;
  logic [NW-1:0] n_m1;
  assign total = TW'(n_r) * TW'(n_r);
  assign n_m1  = n_r - NW'(1);

  // load
  logic [AW-1:0] load_cnt_r;
  logic [AW-1:0] load_inc;
  logic          in_acc;
  logic          run_go;

  assign in_ch.ready = cmd.in_rdy;
  assign in_acc      = in_ch.valid && cmd.in_rdy;
  assign load_inc    = load_cnt_r + AW'(1);
  assign run_go      = in_acc && ((load_inc == '0) || ({1'b0, load_inc} >= total));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
    end else if (in_acc) begin
      load_cnt_r <= run_go ? '0 : load_inc;
    end
  end

  // weight memory
  logic [WW-1:0] wmem [gpm_pkg::MAX_STATES*gpm_pkg::MAX_STATES];
  logic [WW-1:0] rd_q_r;
  logic [AW-1:0] scan_addr_r;

  always_ff @(posedge clk) begin
    if (in_acc) wmem[load_cnt_r] <= in_ch.weight;
  end

  always_ff @(posedge clk) begin
    rd_q_r <= wmem[scan_addr_r];
  end

  // scan counters
  logic [SW-1:0] k_r, j_r, k_d_r, j_d_r;
  logic          rd_vld_r;
  logic          scan_init;
  logic          scan_last;

  assign scan_init = run_go || cmd.pair_b;
  assign scan_last = ({1'b0, scan_addr_r} == total - TW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    k_d_r <= k_r;
    j_d_r <= j_r;
    if (scan_init) begin
      scan_addr_r <= '0;
      k_r         <= '0;
      j_r         <= '0;
    end else if (cmd.scan_issue) begin
      scan_addr_r <= scan_addr_r + AW'(1);
      if ({1'b0, j_r} == n_m1) begin
        j_r <= '0;
        k_r <= k_r + SW'(1);
      end else begin
        j_r <= j_r + SW'(1);
      end
    end
  end

  // best edge search
  logic [gpm_pkg::MAX_STATES-1:0] used_r;
  logic                           found_r;
  logic [WW-1:0]                  best_w_r;
  logic [SW-1:0]                  best_k_r, best_j_r;
  logic                           elig, better;

  assign elig = rd_vld_r && (k_d_r != j_d_r) && !used_r[k_d_r] && !used_r[j_d_r]
                && (rd_q_r > thr_r);
  assign better = elig && (!found_r || (rd_q_r > best_w_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      used_r  <= '0;
    end else begin
      if (scan_init) begin
        found_r <= 1'b0;
      end else if (better) begin
        found_r <= 1'b1;
      end
      if (run_go) begin
        used_r <= '0;
      end else if (cmd.pair_b) begin
        used_r[best_k_r] <= 1'b1;
        used_r[best_j_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_w_r <= rd_q_r;
      best_k_r <= k_d_r;
      best_j_r <= j_d_r;
    end
  end

  // partner memory
  logic [SW-1:0] ptab [gpm_pkg::MAX_STATES];
  logic [SW-1:0] ptab_q_r;
  logic [SW-1:0] emit_s_r;

  always_ff @(posedge clk) begin
    if (cmd.pair_a) begin
      ptab[best_k_r] <= best_j_r;
    end else if (cmd.pair_b) begin
      ptab[best_j_r] <= best_k_r;
    end
  end

  always_ff @(posedge clk) begin
    ptab_q_r <= ptab[emit_s_r];
  end

  // result output register
  logic          out_valid_r;
  logic          out_free;
  logic          emit_fire;
  logic          emit_last;
  logic [SW-1:0] out_state_r, out_partner_r;
  logic          out_paired_r, out_last_r;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign emit_fire = cmd.emit_load && out_free;
  assign emit_last = ({1'b0, emit_s_r} == n_m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      emit_s_r    <= '0;
    end else begin
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (run_go) begin
        emit_s_r <= '0;
      end else if (emit_fire) begin
        emit_s_r <= emit_s_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_state_r   <= emit_s_r;
      out_partner_r <= used_r[emit_s_r] ? ptab_q_r : '0;
      out_paired_r  <= used_r[emit_s_r];
      out_last_r    <= emit_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.state_index   = out_state_r;
  assign out_ch.partner_index = out_partner_r;
  assign out_ch.paired        = out_paired_r;
  assign out_ch.last_result   = out_last_r;

  assign sts.run_go    = run_go;
  assign sts.scan_last = scan_last;
  assign sts.found     = found_r;
  assign sts.out_free  = out_free;
  assign sts.emit_last = emit_last;

  a_used_even: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(used_r) & 1) == 0)
    else $error("used flags count is odd");

  a_found_above_thr: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> best_w_r > thr_r)
    else $error("selected edge not above threshold");

  a_pair_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pair_a |-> (best_k_r != best_j_r) && !used_r[best_k_r] && !used_r[best_j_r])
    else $error("pairing an invalid or used edge");

endmodule
